### hdl/tea_pkg.sv
// tea_pkg: shared types, constants and the TEA round function for the
// rotating-key TEA block cipher. No dependencies.
package tea_pkg;

	localparam int ROUND_PAIRS = 32;
	localparam int MAX_KEYS    = 3;
	localparam int STAGES      = 2 * ROUND_PAIRS;
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

	localparam logic [2:0] REG_DECRYPT_MODE = 3'd0;
	localparam logic [2:0] REG_KEY_COUNT    = 3'd1;
	localparam logic [2:0] REG_KEY0_UPPER   = 3'd2;
	localparam logic [2:0] REG_KEY0_LOWER   = 3'd3;
	localparam logic [2:0] REG_KEY1_UPPER   = 3'd4;
	localparam logic [2:0] REG_KEY1_LOWER   = 3'd5;
	localparam logic [2:0] REG_KEY2_UPPER   = 3'd6;
	localparam logic [2:0] REG_KEY2_LOWER   = 3'd7;

	typedef struct packed {
		logic                 decrypt_mode;
		logic [1:0]           key_count;
		logic [2:0][63:0]     key_upper;
		logic [2:0][63:0]     key_lower;
	} cfg_t;

	typedef struct packed {
		logic [63:0] blk;
		logic [1:0]  ksel;
	} item_t;

	function automatic logic [31:0] tea_mix(input logic [31:0] src, input logic [31:0] ka,
			input logic [31:0] kb, input logic [31:0] sum);
		tea_mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
	endfunction

endpackage

### hdl/tea_block_cipher_key_rotating.sv
// tea_block_cipher_key_rotating: top level, configuration registers and
// front / queue / core. Depends on tea_pkg, tea_front, tea_queue, tea_core.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   input    | push / full           | block_in[63:0], first_block
//   result   | pop / empty           | block_out[63:0]
//   config   | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[63:0]
//
// One block per cycle sustained while results are popped; an accepted block passes the
// queue and then the 64 half-round stages, the last being the result register.
// The core pipeline advances as a whole when its result register is empty or popped;
// the two-entry queue absorbs the front while the core stalls.
// Reset clears key position, keys, decrypt mode and valid state; cfg_ready is always high.
module tea_block_cipher_key_rotating (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] block_in,
	input  logic        first_block,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] block_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	tea_pkg::cfg_t  cfg_q;
	tea_pkg::item_t fq_item;
	tea_pkg::item_t qc_item;
	logic           fq_push;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decrypt_mode <= 1'b0;
			cfg_q.key_count    <= 2'd1;
			cfg_q.key_upper    <= '0;
			cfg_q.key_lower    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tea_pkg::REG_DECRYPT_MODE: cfg_q.decrypt_mode <= cfg_data[0];
				tea_pkg::REG_KEY_COUNT:    cfg_q.key_count    <= cfg_data[1:0];
				tea_pkg::REG_KEY0_UPPER:   cfg_q.key_upper[0] <= cfg_data;
				tea_pkg::REG_KEY0_LOWER:   cfg_q.key_lower[0] <= cfg_data;
				tea_pkg::REG_KEY1_UPPER:   cfg_q.key_upper[1] <= cfg_data;
				tea_pkg::REG_KEY1_LOWER:   cfg_q.key_lower[1] <= cfg_data;
				tea_pkg::REG_KEY2_UPPER:   cfg_q.key_upper[2] <= cfg_data;
				tea_pkg::REG_KEY2_LOWER:   cfg_q.key_lower[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tea_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.block_in    (block_in),
		.first_block (first_block),
		.q_full      (q_full),
		.q_push      (fq_push),
		.q_item      (fq_item)
	);

	tea_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fq_push),
		.wr_item (fq_item),
		.full    (q_full),
		.rd      (q_pop),
		.rd_item (qc_item),
		.empty   (q_empty)
	);

	tea_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_item    (qc_item),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.block_out (block_out)
	);

endmodule

### hdl/tea_front.sv
// tea_front: accepts input transactions and assigns each block its key index.
// Depends on tea_pkg.
module tea_front (
	input  logic           clk,
	input  logic           arst_n,
	input  tea_pkg::cfg_t  cfg,
	input  logic           push,
	input  logic [63:0]    block_in,
	input  logic           first_block,
	input  logic           q_full,
	output logic           q_push,
	output tea_pkg::item_t q_item
);

	logic [1:0] key_pos_q;
	logic [1:0] n_keys;
	logic [1:0] sel;
	logic [1:0] sel_inc;

	always_comb begin
		n_keys = cfg.key_count;
		if (n_keys == 2'd0) begin
			n_keys = 2'd1;
		end
		if (n_keys > 2'(tea_pkg::MAX_KEYS)) begin
			n_keys = 2'(tea_pkg::MAX_KEYS);
		end
		sel = (first_block || key_pos_q >= n_keys) ? 2'd0 : key_pos_q;
		sel_inc = sel + 2'd1;
		if (sel_inc >= n_keys) begin
			sel_inc = 2'd0;
		end
	end

	assign q_push      = push && !q_full;
	assign q_item.blk  = block_in;
	assign q_item.ksel = sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= 2'd0;
		end else if (q_push) begin
			key_pos_q <= sel_inc;
		end
	end

endmodule

### hdl/tea_queue.sv
// tea_queue: short queue between front and back, register based.
// Depends on tea_pkg.
module tea_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tea_pkg::item_t wr_item,
	output logic           full,
	input  logic           rd,
	output tea_pkg::item_t rd_item,
	output logic           empty
);

	tea_pkg::item_t                 mem_q [tea_pkg::QUEUE_DEPTH];
	logic [tea_pkg::QUEUE_AW-1:0]   wptr_q;
	logic [tea_pkg::QUEUE_AW-1:0]   rptr_q;
	logic [tea_pkg::QUEUE_AW:0]     cnt_q;

	assign full    = cnt_q == (tea_pkg::QUEUE_AW+1)'(tea_pkg::QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

endmodule

### hdl/tea_core.sv
// tea_core: unrolled TEA datapath, one half-round per pipeline stage; the last
// stage is the result register. Depends on tea_pkg.
module tea_core (
	input  logic           clk,
	input  logic           arst_n,
	input  tea_pkg::cfg_t  cfg,
	input  logic           q_empty,
	input  tea_pkg::item_t q_item,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output logic [63:0]    block_out
);

	localparam int Stages = tea_pkg::STAGES;

	logic [Stages-1:0]        vld_s;
	logic [Stages-1:0][63:0]  blk_s;
	logic [Stages-1:0][1:0]   ksel_s;
	logic [Stages-1:0][63:0]  nxt_blk;
	logic [Stages-1:0][1:0]   nxt_ksel;
	logic                     advance;

	assign advance   = !vld_s[Stages-1] || pop;
	assign q_pop     = advance && !q_empty;
	assign empty     = !vld_s[Stages-1];
	assign block_out = blk_s[Stages-1];

	for (genvar h = 0; h < Stages; h++) begin : g_stage
		localparam int Pair = h / 2;
		localparam logic [31:0] SumEnc = tea_pkg::TEA_DELTA * 32'(Pair + 1);
		localparam logic [31:0] SumDec = tea_pkg::TEA_DELTA * 32'(tea_pkg::ROUND_PAIRS - Pair);

		logic [63:0] src_blk;
		logic [1:0]  src_ksel;
		logic [31:0] v0, v1, k0, k1, k2, k3;

		if (h == 0) begin : g_head
			assign src_blk  = q_item.blk;
			assign src_ksel = q_item.ksel;
		end else begin : g_body
			assign src_blk  = blk_s[h-1];
			assign src_ksel = ksel_s[h-1];
		end

		assign v0 = src_blk[63:32];
		assign v1 = src_blk[31:0];
		assign k0 = cfg.key_upper[src_ksel][63:32];
		assign k1 = cfg.key_upper[src_ksel][31:0];
		assign k2 = cfg.key_lower[src_ksel][63:32];
		assign k3 = cfg.key_lower[src_ksel][31:0];
		assign nxt_ksel[h] = src_ksel;

		if (h % 2 == 0) begin : g_even
			always_comb begin
				if (cfg.decrypt_mode) begin
					nxt_blk[h] = {v0, v1 - tea_pkg::tea_mix(v0, k2, k3, SumDec)};
				end else begin
					nxt_blk[h] = {v0 + tea_pkg::tea_mix(v1, k0, k1, SumEnc), v1};
				end
			end
		end else begin : g_odd
			always_comb begin
				if (cfg.decrypt_mode) begin
					nxt_blk[h] = {v0 - tea_pkg::tea_mix(v1, k0, k1, SumDec), v1};
				end else begin
					nxt_blk[h] = {v0, v1 + tea_pkg::tea_mix(v0, k2, k3, SumEnc)};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[Stages-2:0], q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blk_s  <= nxt_blk;
			ksel_s <= nxt_ksel;
		end
	end

endmodule

### verif/tea_cipher_checker.sv
// tea_cipher_checker: watches the config, input and result channels of the
// rotating-key TEA cipher, predicts each output block and compares it.
// Depends on tea_pkg.
`timescale 1ns / 100ps

module tea_cipher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [63:0] block_in,
	input  logic        first_block,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] block_out,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          outstanding,
	output int          fail_count
);

	tea_pkg::cfg_t cipher_cfg;
	logic [1:0]    key_pos;
	logic [63:0]   blocks_due [$];
	int            mismatches;
	int            active_keys;
	logic [1:0]    key_sel;
	logic [63:0]   want;

	function automatic logic [63:0] tea_transform(input logic [63:0] blk,
			input logic [63:0] key_up, input logic [63:0] key_lo, input logic decrypt);
		logic [31:0] v0, v1, k0, k1, k2, k3, sum;
		v0 = blk[63:32];
		v1 = blk[31:0];
		k0 = key_up[63:32];
		k1 = key_up[31:0];
		k2 = key_lo[63:32];
		k3 = key_lo[31:0];
		if (!decrypt) begin
			sum = '0;
			for (int r = 0; r < tea_pkg::ROUND_PAIRS; r++) begin
				sum += tea_pkg::TEA_DELTA;
				v0 += ((v1 << 4) + k0) ^ (v1 + sum) ^ ((v1 >> 5) + k1);
				v1 += ((v0 << 4) + k2) ^ (v0 + sum) ^ ((v0 >> 5) + k3);
			end
		end else begin
			sum = tea_pkg::TEA_DELTA * 32'(tea_pkg::ROUND_PAIRS);
			for (int r = 0; r < tea_pkg::ROUND_PAIRS; r++) begin
				v1 -= ((v0 << 4) + k2) ^ (v0 + sum) ^ ((v0 >> 5) + k3);
				v0 -= ((v1 << 4) + k0) ^ (v1 + sum) ^ ((v1 >> 5) + k1);
				sum -= tea_pkg::TEA_DELTA;
			end
		end
		return {v0, v1};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_cfg              = '0;
			cipher_cfg.key_count    = 2'd1;
			key_pos                 = '0;
			blocks_due.delete();
			mismatches              = 0;
			outstanding             <= 0;
			fail_count              <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tea_pkg::REG_DECRYPT_MODE: cipher_cfg.decrypt_mode = cfg_data[0];
					tea_pkg::REG_KEY_COUNT:    cipher_cfg.key_count    = cfg_data[1:0];
					tea_pkg::REG_KEY0_UPPER:   cipher_cfg.key_upper[0] = cfg_data;
					tea_pkg::REG_KEY0_LOWER:   cipher_cfg.key_lower[0] = cfg_data;
					tea_pkg::REG_KEY1_UPPER:   cipher_cfg.key_upper[1] = cfg_data;
					tea_pkg::REG_KEY1_LOWER:   cipher_cfg.key_lower[1] = cfg_data;
					tea_pkg::REG_KEY2_UPPER:   cipher_cfg.key_upper[2] = cfg_data;
					tea_pkg::REG_KEY2_LOWER:   cipher_cfg.key_lower[2] = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				// zero count acts as one; position past the count falls back to key 0
				active_keys = (cipher_cfg.key_count == 0) ? 1 :
					(cipher_cfg.key_count > tea_pkg::MAX_KEYS) ? tea_pkg::MAX_KEYS :
					int'(cipher_cfg.key_count);
				key_sel = key_pos;
				if (first_block || key_sel >= active_keys)
					key_sel = '0;
				blocks_due.push_back(tea_transform(block_in, cipher_cfg.key_upper[key_sel],
					cipher_cfg.key_lower[key_sel], cipher_cfg.decrypt_mode));
				key_pos = (int'(key_sel) + 1 >= active_keys) ? 2'd0 : key_sel + 2'd1;
			end
			if (pop && !empty) begin
				if (blocks_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: block_out %h with no transaction pending", $realtime,
							block_out);
				end else begin
					want = blocks_due.pop_front();
					if (block_out !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: block_out mismatch: expected %h, got %h", $realtime,
								want, block_out);
					end
				end
			end
			outstanding <= blocks_due.size();
			fail_count  <= mismatches;
		end
	end

endmodule

### verif/tea_block_cipher_key_rotating_test.sv
// tea_block_cipher_key_rotating_test: drives config writes, blocks and pops
// into the rotating-key TEA cipher and reports the verdict.
// Depends on tea_pkg, tea_block_cipher_key_rotating and tea_cipher_checker.
`timescale 1ns / 100ps

module tea_block_cipher_key_rotating_test;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic        full;
	logic [63:0] block_in    = '0;
	logic        first_block = 1'b0;
	logic        empty;
	logic        pop         = 1'b0;
	logic [63:0] block_out;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index   = '0;
	logic [63:0] cfg_data    = '0;
	int          outstanding;
	int          fail_count;
	int          tx_idle_pct = 7;
	int          rx_idle_pct = 63;

	logic [2:0] key_regs [6] = '{tea_pkg::REG_KEY0_UPPER, tea_pkg::REG_KEY0_LOWER,
		tea_pkg::REG_KEY1_UPPER, tea_pkg::REG_KEY1_LOWER, tea_pkg::REG_KEY2_UPPER,
		tea_pkg::REG_KEY2_LOWER};

	tea_block_cipher_key_rotating u_dut (.*);

	tea_cipher_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk)
		pop <= arst_n && ($urandom_range(99) >= rx_idle_pct);

	function automatic logic [63:0] rand_value();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			2:       return 64'h1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_block(input logic [63:0] blk, input logic first);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		block_in    <= blk;
		first_block <= first;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		push      <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: encrypt, single all-zero key
		send_block('0, 1'b0);
		send_block('1, 1'b0);
		drain();

		write_reg(tea_pkg::REG_DECRYPT_MODE, 64'd0);
		write_reg(tea_pkg::REG_KEY_COUNT, 64'd3);
		write_reg(tea_pkg::REG_KEY0_UPPER, '1);
		write_reg(tea_pkg::REG_KEY0_LOWER, '1);
		write_reg(tea_pkg::REG_KEY1_UPPER, {$urandom, $urandom});
		write_reg(tea_pkg::REG_KEY1_LOWER, {$urandom, $urandom});
		write_reg(tea_pkg::REG_KEY2_UPPER, 64'h0123_4567_89AB_CDEF);
		write_reg(tea_pkg::REG_KEY2_LOWER, 64'hFEDC_BA98_7654_3210);
		cfg_valid <= 1'b0;
		send_block('1, 1'b1);
		send_block('0, 1'b0);
		send_block({$urandom, $urandom}, 1'b0);
		send_block({$urandom, $urandom}, 1'b0);
		send_block({$urandom, $urandom}, 1'b1);
		send_block(64'h8000_0000_0000_0001, 1'b0);
		drain();

		// rotation now points at key 2; shrinking the count leaves it stale
		write_reg(tea_pkg::REG_DECRYPT_MODE, 64'd1);
		write_reg(tea_pkg::REG_KEY_COUNT, 64'd2);
		cfg_valid <= 1'b0;
		send_block('0, 1'b0);
		send_block('1, 1'b0);
		send_block({$urandom, $urandom}, 1'b0);
		send_block({$urandom, $urandom}, 1'b0);
		drain();

		write_reg(tea_pkg::REG_KEY_COUNT, 64'd0);
		cfg_valid <= 1'b0;
		send_block({$urandom, $urandom}, 1'b0);
		send_block({$urandom, $urandom}, 1'b1);
		send_block({$urandom, $urandom}, 1'b0);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			tx_idle_pct = (ph < 3) ? 7 : (ph < 6) ? 63 : 0;
			rx_idle_pct = (ph < 3) ? 63 : (ph < 6) ? 7 : 0;
			write_reg(tea_pkg::REG_DECRYPT_MODE, 64'($urandom_range(1)));
			write_reg(tea_pkg::REG_KEY_COUNT, 64'($urandom_range(3)));
			for (int k = 0; k < 6; k++)
				if ($urandom_range(1))
					write_reg(key_regs[k], rand_value());
			cfg_valid <= 1'b0;
			repeat (95)
				send_block(rand_value(), $urandom_range(7) == 0);
			drain();
		end

		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/tea_pkg.sv
hdl/tea_front.sv
hdl/tea_queue.sv
hdl/tea_core.sv
hdl/tea_block_cipher_key_rotating.sv
verif/tea_cipher_checker.sv
verif/tea_block_cipher_key_rotating_test.sv
